// ===== src/rtt_pkg.sv =====
// package for the range translation table: request and status codes, sequencer states
package rtt_pkg;

  localparam int unsigned VAL_W = 48;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_SCAN,
    ST_SUB,
    ST_FIN,
    ST_OUT
  } state_e;

endpackage

// ===== src/range_translation_table.sv =====
// range translation table: sorted range store with insert and translate sequencer
//
// Holds up to TABLE_DEPTH ranges (source start, destination start, length) in a memory with
// one write port and one registered read port, kept sorted by source start. One item is
// handled at a time and each gives one result. A clear or an unknown request goes straight
// to ST_OUT. An add reads entries from the back and shifts each one with a larger source
// start up by one place to make room (ST_ADD_RD, ST_ADD_CMP), then writes the range
// (ST_ADD_PUT); ST_ADD_CMP is skipped when the table is empty, and a full table drops the
// range with status 1. A translate walks the stored entries through the memory read port,
// one per cycle, then does the remap subtract (ST_SUB) and the add/compare (ST_FIN), the
// latter skipped when no entry lies at or below the value. A finished result waits in ST_OUT
// for out_ready_i while the output register is full. Results sit in an output register, so
// the next item can be taken while a result waits. Values are taken modulo 2^VALUE_WIDTH,
// at most 2^VAL_W, and a remap above that saturates with status 2 when VALUE_WIDTH <= VAL_W.
module range_translation_table
  import rtt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [VAL_W-1:0] lookup_value_i,
  input  logic [VAL_W-1:0] source_start_i,
  input  logic [VAL_W-1:0] dest_start_i,
  input  logic [VAL_W-1:0] range_length_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [VAL_W-1:0] mapped_value_o,
  output logic             hit_o
);

  localparam int unsigned SW     = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EW     = 3 * SW;
  localparam bit          SAT_EN = (VALUE_WIDTH <= VAL_W);

  state_e state_q, state_d;

  logic [1:0]    req_q;
  logic [SW-1:0] v_q, s_q, d_q, len_q;
  logic [CW-1:0] cnt_q, pos_q, idx_q;
  logic          rd_vld_q, found_q;
  logic [SW-1:0] best_src_q, best_dst_q, best_len_q, diff_q;
  logic [1:0]    res_status_q;
  logic [SW-1:0] res_val_q;
  logic          res_hit_q;
  logic          out_vld_q;
  logic [1:0]    out_status_q;
  logic [SW-1:0] out_val_q;
  logic          out_hit_q;

  logic [EW-1:0] tbl_mem_q [TABLE_DEPTH];
  logic [EW-1:0] rd_data_q;

  logic          mem_we;
  logic [CW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;
  logic          in_acc, out_free, shift_up, scan_issue, scan_take, tbl_full;
  logic [SW-1:0] rd_src, rd_dst, rd_len;
  logic [SW:0]   sum;
  logic          in_range, sat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;

  assign rd_src = rd_data_q[EW-1:2*SW];
  assign rd_dst = rd_data_q[2*SW-1:SW];
  assign rd_len = rd_data_q[SW-1:0];

  assign tbl_full   = (cnt_q == CW'(TABLE_DEPTH));
  assign shift_up   = (state_q == ST_ADD_CMP) && (rd_src > s_q);
  assign scan_issue = (state_q == ST_SCAN) && (idx_q < cnt_q);
  assign scan_take  = rd_vld_q && (rd_src <= v_q) && (!found_q || (rd_src > best_src_q));

  assign in_range = (diff_q < best_len_q);
  assign sum      = {1'b0, diff_q} + {1'b0, best_dst_q};
  assign sat      = SAT_EN && sum[SW];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            REQ_ADD:   state_d = ST_ADD_RD;
            REQ_XLATE: state_d = ST_SCAN;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_ADD_RD: begin
        if (tbl_full) begin
          state_d = ST_OUT;
        end else if (pos_q == '0) begin
          state_d = ST_ADD_PUT;
        end else begin
          state_d = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (!shift_up || (pos_q == CW'(1))) begin
          state_d = ST_ADD_PUT;
        end
      end
      ST_ADD_PUT: state_d = ST_OUT;
      ST_SCAN: begin
        if (!scan_issue) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: state_d = found_q ? ST_FIN : ST_OUT;
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pos_q;
    mem_wd = {s_q, d_q, len_q};
    mem_ra = idx_q;
    unique case (state_q)
      ST_ADD_RD: begin
        mem_ra = pos_q - CW'(1);
      end
      ST_ADD_CMP: begin
        mem_ra = pos_q - CW'(2);
        if (shift_up) begin
          mem_we = 1'b1;
          mem_wd = rd_data_q;
        end
      end
      ST_ADD_PUT: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem_q[mem_wa[AW-1:0]] <= mem_wd;
    end
    rd_data_q <= tbl_mem_q[mem_ra[AW-1:0]];
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            pos_q    <= cnt_q;
            idx_q    <= '0;
            rd_vld_q <= 1'b0;
            found_q  <= 1'b0;
            if (req_type_i == REQ_CLEAR) begin
              cnt_q <= '0;
            end
          end
        end
        ST_ADD_CMP: begin
          if (shift_up) begin
            pos_q <= pos_q - CW'(1);
          end
        end
        ST_ADD_PUT: begin
          cnt_q <= cnt_q + CW'(1);
        end
        ST_SCAN: begin
          rd_vld_q <= scan_issue;
          if (scan_issue) begin
            idx_q <= idx_q + CW'(1);
          end
          if (scan_take) begin
            found_q <= 1'b1;
          end
        end
        default: begin
          rd_vld_q <= 1'b0;
        end
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_q        <= req_type_i;
          v_q          <= lookup_value_i[SW-1:0];
          s_q          <= source_start_i[SW-1:0];
          d_q          <= dest_start_i[SW-1:0];
          len_q        <= range_length_i[SW-1:0];
          res_status_q <= STAT_OK;
          res_val_q    <= '0;
          res_hit_q    <= 1'b0;
        end
      end
      ST_ADD_RD: begin
        if (tbl_full) begin
          res_status_q <= STAT_FULL;
        end
      end
      ST_SCAN: begin
        if (scan_take) begin
          best_src_q <= rd_src;
          best_dst_q <= rd_dst;
          best_len_q <= rd_len;
        end
      end
      ST_SUB: begin
        diff_q    <= v_q - best_src_q;
        res_val_q <= v_q;
      end
      ST_FIN: begin
        if (in_range) begin
          res_hit_q    <= 1'b1;
          res_val_q    <= sat ? '1 : sum[SW-1:0];
          res_status_q <= sat ? STAT_SAT : STAT_OK;
        end
      end
      default: begin
        res_hit_q <= res_hit_q;
      end
    endcase
    if (state_q == ST_OUT && out_free) begin
      out_status_q <= res_status_q;
      out_val_q    <= res_val_q;
      out_hit_q    <= res_hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_status_q;
  assign mapped_value_o = VAL_W'(out_val_q);
  assign hit_o          = out_hit_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == '0)))
    else $error("entry count moved by more than one");

  a_write_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == ST_ADD_CMP) || (state_q == ST_ADD_PUT)) && (req_q == REQ_ADD))
    else $error("table written outside an add");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_CMP) |-> (pos_q != '0))
    else $error("shift step with insert position at zero");

  a_full_nohit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_status_q == STAT_FULL)) |-> !out_hit_q)
    else $error("dropped range reported a hit");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the range translation table: directed table then random phases, self-checking
module testbench;
  import rtt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [VAL_W-1:0] MAXV = {VAL_W{1'b1}};

  typedef struct packed {
    logic [1:0]       req;
    logic [VAL_W-1:0] lookup;
    logic [VAL_W-1:0] src;
    logic [VAL_W-1:0] dst;
    logic [VAL_W-1:0] len;
  } rtt_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] mapped;
    logic             hit;
  } rtt_result_t;

  typedef struct {
    rtt_item_t   item;
    bit          known;
    rtt_result_t res;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready_o;
  logic [1:0]       req_type;
  logic [VAL_W-1:0] lookup_value;
  logic [VAL_W-1:0] source_start;
  logic [VAL_W-1:0] dest_start;
  logic [VAL_W-1:0] range_length;
  logic             out_valid_o;
  logic             out_ready;
  logic [1:0]       status_o;
  logic [VAL_W-1:0] mapped_value_o;
  logic             hit_o;

  logic [VAL_W-1:0] map_src [TABLE_DEPTH];
  logic [VAL_W-1:0] map_dst [TABLE_DEPTH];
  logic [VAL_W-1:0] map_len [TABLE_DEPTH];
  int               map_count;

  rtt_result_t pending_results[$];
  dir_row_t    dir_rows[$];
  int          errors = 0;
  int          idle_cycles;
  bit          calm;

  range_translation_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VAL_W)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type),
    .lookup_value_i(lookup_value),
    .source_start_i(source_start),
    .dest_start_i  (dest_start),
    .range_length_i(range_length),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .mapped_value_o(mapped_value_o),
    .hit_o         (hit_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rtt_result_t table_result(input rtt_item_t it);
    rtt_result_t      r;
    int               pos;
    int               sel;
    bit               found;
    logic [VAL_W-1:0] diff;
    logic [VAL_W:0]   sum;
    r = '0;
    found = 1'b0;
    sel = 0;
    case (it.req)
      REQ_CLEAR: map_count = 0;
      REQ_ADD: begin
        if (map_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = map_count;
          while (pos > 0 && map_src[pos-1] > it.src) begin
            map_src[pos] = map_src[pos-1];
            map_dst[pos] = map_dst[pos-1];
            map_len[pos] = map_len[pos-1];
            pos--;
          end
          map_src[pos] = it.src;
          map_dst[pos] = it.dst;
          map_len[pos] = it.len;
          map_count++;
        end
      end
      REQ_XLATE: begin
        r.mapped = it.lookup;
        for (int i = 0; i < map_count; i++) begin
          if (map_src[i] <= it.lookup && (!found || map_src[i] > map_src[sel])) begin
            sel = i;
            found = 1'b1;
          end
        end
        if (found) begin
          diff = it.lookup - map_src[sel];
          if (diff < map_len[sel]) begin
            sum = {1'b0, diff} + {1'b0, map_dst[sel]};
            r.hit = 1'b1;
            if (sum[VAL_W]) begin
              r.mapped = MAXV;
              r.status = STAT_SAT;
            end else begin
              r.mapped = sum[VAL_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] pick_src();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_val();
      4, 5:       return VAL_W'($urandom_range(0, 4000));
      6:          return MAXV - VAL_W'($urandom_range(0, 4000));
      7:          return (map_count > 0) ? map_src[$urandom_range(0, map_count - 1)] : rand_val();
      8:          return '0;
      default:    return rand_val() >> $urandom_range(0, VAL_W - 1);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_dst();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return rand_val();
      6, 7:             return MAXV - VAL_W'($urandom_range(0, 500));
      8:                return '0;
      default:          return VAL_W'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:             return '0;
      1, 2, 3, 4, 5: return VAL_W'($urandom_range(1, 1000));
      6, 7:          return rand_val();
      8:             return MAXV;
      default:       return rand_val() >> $urandom_range(0, VAL_W - 1);
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_lookup();
    int               k;
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] l;
    if (map_count == 0 || $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return MAXV;
        default: return rand_val();
      endcase
    end
    k = $urandom_range(0, map_count - 1);
    s = map_src[k];
    l = map_len[k];
    case ($urandom_range(0, 6))
      0:       return s;
      1:       return s - 1'b1;
      2:       return s + l - 1'b1;
      3:       return s + l;
      4:       return (l == '0) ? s : s + (rand_val() % l);
      5:       return s + VAL_W'($urandom_range(0, 3));
      default: return rand_val();
    endcase
  endfunction

  function automatic dir_row_t row(input logic [1:0] req, input logic [VAL_W-1:0] lookup,
                                   input logic [VAL_W-1:0] src, input logic [VAL_W-1:0] dst,
                                   input logic [VAL_W-1:0] len, input bit known,
                                   input logic [1:0] st, input logic [VAL_W-1:0] mv,
                                   input logic hit);
    dir_row_t d;
    d.item  = '{req: req, lookup: lookup, src: src, dst: dst, len: len};
    d.known = known;
    d.res   = '{status: st, mapped: mv, hit: hit};
    return d;
  endfunction

  // starts after an accepting edge (or reset), returns at the accepting edge
  task automatic drive_item(input rtt_item_t it, input bit known, input rtt_result_t want);
    int          gap;
    rtt_result_t r;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= it.req;
    lookup_value <= it.lookup;
    source_start <= it.src;
    dest_start   <= it.dst;
    range_length <= it.len;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    r = table_result(it);
    pending_results.push_back(known ? want : r);
  endtask

  task automatic send(input rtt_item_t it);
    drive_item(it, 1'b0, '0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0 && !calm) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = 0;
        if (!calm && $urandom_range(0, 5) == 0) hold = pick_gap() + 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    rtt_result_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d mapped %0h hit %0d",
               status_o, mapped_value_o, hit_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (mapped_value_o !== want.mapped) begin
          $error("mapped_value: expected %0h, got %0h", want.mapped, mapped_value_o);
          errors++;
        end
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    rtt_item_t it;
    int        sent;
    int        n;
    int        full_phases;
    bit        pressed;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    req_type     = REQ_CLEAR;
    lookup_value = '0;
    source_start = '0;
    dest_start   = '0;
    range_length = '0;
    calm         = 1'b0;
    map_count    = 0;
    sent         = 0;
    full_phases  = 0;
    pressed      = 1'b0;

    dir_rows.push_back(row(REQ_XLATE, '0, '0, '0, '0, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, MAXV, MAXV, MAXV, MAXV, 1, STAT_OK, MAXV, 0));
    dir_rows.push_back(row(REQ_NONE, MAXV, MAXV, MAXV, MAXV, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_ADD, '0, 100, 1000, 10, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 100, '0, '0, '0, 1, STAT_OK, 1000, 1));
    dir_rows.push_back(row(REQ_XLATE, 109, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 110, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 99, '0, '0, '0, 0, STAT_OK, '0, 0));
    // same source start again, the older entry has to win
    dir_rows.push_back(row(REQ_ADD, '0, 100, 5000, 50, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 105, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 120, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_ADD, '0, 200, '0, '0, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 200, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_ADD, '0, '0, MAXV, MAXV, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 50, '0, '0, '0, 1, STAT_SAT, MAXV, 1));
    dir_rows.push_back(row(REQ_XLATE, '0, '0, '0, '0, 1, STAT_OK, MAXV, 1));
    dir_rows.push_back(row(REQ_ADD, '0, MAXV, '0, 1, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, MAXV, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_CLEAR, MAXV, MAXV, MAXV, MAXV, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, 100, '0, '0, '0, 1, STAT_OK, 100, 0));
    dir_rows.push_back(row(REQ_ADD, '0, '0, '0, MAXV, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, MAXV, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_ADD, '0, MAXV, MAXV, MAXV, 1, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_XLATE, MAXV, '0, '0, '0, 0, STAT_OK, '0, 0));
    dir_rows.push_back(row(REQ_CLEAR, '0, '0, '0, '0, 1, STAT_OK, '0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].res);

    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if (!pressed || $urandom_range(0, 5) == 0) begin
        wait_drained();
        pressed = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        repeat (8) begin
          it = '{req: 2'($urandom_range(0, 3)), lookup: rand_val(), src: rand_val(),
                 dst: rand_val(), len: rand_val()};
          send(it);
          if (it.req != REQ_NONE) sent++;
        end
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          it = '{req: REQ_CLEAR, lookup: rand_val(), src: rand_val(), dst: rand_val(),
                 len: rand_val()};
          send(it);
          sent++;
        end
        if (full_phases < 3 && $urandom_range(0, 9) == 0) begin
          n = $urandom_range(62, 68);
          full_phases++;
        end else begin
          n = $urandom_range(1, 8);
        end
        repeat (n) begin
          it = '{req: REQ_ADD, lookup: rand_val(), src: pick_src(), dst: pick_dst(),
                 len: pick_len()};
          send(it);
          sent++;
        end
        repeat ($urandom_range(3, 12)) begin
          it = '{req: REQ_XLATE, lookup: pick_lookup(), src: rand_val(), dst: rand_val(),
                 len: rand_val()};
          send(it);
          sent++;
        end
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/rtt_pkg.sv
src/range_translation_table.sv
tb/sv/testbench.sv
